/* hdl/obp_pkg.sv */
package obp_pkg;

	localparam int STORE_DEPTH_DEF = 4096;
	localparam int SEQ_DEPTH_DEF   = 256;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ_WAIT,
		BK_SCAN_RD,
		BK_SCAN_CMP,
		BK_CHECK,
		BK_APP_RD,
		BK_APP_WR
	} back_state_t;

endpackage

/* hdl/obp_front.sv */
module obp_front
	import obp_pkg::*;
#(
	parameter int AW   = 12,
	parameter int IN_W = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,   // data_byte, read_address
	input  logic [1:0]      s_axis_tuser,   // kind
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output kind_t           cmd_kind,
	output logic [7:0]      cmd_data,
	output logic [AW-1:0]   cmd_addr
);

	logic          valid_s1;
	kind_t         kind_s1;
	logic [7:0]    data_s1;
	logic [AW-1:0] addr_s1;

	assign s_axis_tready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// split the transaction into its command fields
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= kind_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata[7:0];
			addr_s1 <= s_axis_tdata[8 +: AW];
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd_kind  = kind_s1;
	assign cmd_data  = data_s1;
	assign cmd_addr  = addr_s1;

endmodule

/* hdl/obp_queue.sv */
module obp_queue
	import obp_pkg::*;
#(
	parameter int W     = 22,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = count_q != NW'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

/* hdl/obp_back.sv */
module obp_back
	import obp_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH),
	localparam int TW = $clog2(STORE_DEPTH + 1),
	localparam int QW = $clog2(SEQ_DEPTH),
	localparam int CW = $clog2(SEQ_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  kind_t         cmd_kind,
	input  logic [7:0]    cmd_data,
	input  logic [AW-1:0] cmd_addr,
	output logic          res_valid,
	input  logic          res_ready,
	output kind_t         res_kind,
	output logic [AW-1:0] res_offset,
	output logic [CW-1:0] res_length,
	output logic [7:0]    res_byte,
	output logic [TW-1:0] res_top,
	output status_t       res_status
);

	localparam int SW = ((TW > CW) ? TW : CW) + 1;

	back_state_t   state_q, state_d;
	logic [TW-1:0] top_q, top_d;
	logic [CW-1:0] count_q, count_d;
	logic [TW-1:0] pos_q, pos_d;
	logic [CW-1:0] matched_q, matched_d;
	logic [AW-1:0] start_q, start_d;
	logic          have_q, have_d;
	logic [AW-1:0] off_q, off_d;

	logic [7:0]    store_mem [STORE_DEPTH];
	logic [7:0]    pend_mem [SEQ_DEPTH];
	logic [7:0]    st_rdata_q;
	logic [7:0]    pd_rdata_q;
	logic [AW-1:0] st_raddr;
	logic          st_we;
	logic          pd_we;

	logic          out_valid_q;
	kind_t         out_kind_q;
	logic [AW-1:0] out_off_q;
	logic [CW-1:0] out_len_q;
	logic [7:0]    out_byte_q;
	logic [TW-1:0] out_top_q;
	status_t       out_status_q;

	logic          emit;
	kind_t         e_kind;
	logic [AW-1:0] e_off;
	logic [CW-1:0] e_len;
	logic [7:0]    e_byte;
	logic [TW-1:0] e_top;
	status_t       e_status;

	logic          out_free;
	logic          pop;
	logic          match;
	logic [CW-1:0] matched_inc;
	logic          last_match;
	logic [TW-1:0] pos_inc;
	logic [TW-1:0] pos_nx;
	logic [SW-1:0] need;
	logic          fits;
	logic          addr_beyond;
	logic          pend_full;

	assign out_free    = !out_valid_q || res_ready;
	assign pop         = (state_q == BK_IDLE) && cmd_valid && out_free;
	assign cmd_ready   = pop;
	assign match       = st_rdata_q == pd_rdata_q;
	assign matched_inc = matched_q + CW'(1);
	assign last_match  = matched_inc == count_q;
	assign pos_inc     = pos_q + TW'(1);
	// on a mismatch after a partial match, restart one past its start
	assign pos_nx      = (match || !have_q) ? pos_inc : TW'(start_q) + TW'(1);
	assign need        = SW'(count_q) - SW'(matched_q);
	assign fits        = (SW'(top_q) + need) <= SW'(STORE_DEPTH);
	assign addr_beyond = TW'(cmd_addr) >= top_q;
	assign pend_full   = count_q == CW'(SEQ_DEPTH);
	assign st_raddr    = (state_q == BK_IDLE) ? cmd_addr : pos_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[top_q[AW-1:0]] <= pd_rdata_q;
		end
		st_rdata_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (pd_we) begin
			pend_mem[count_q[QW-1:0]] <= cmd_data;
		end
		pd_rdata_q <= pend_mem[matched_q[QW-1:0]];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					unique case (cmd_kind)
						KIND_FINISH: begin
							if (count_q != '0) begin
								state_d = (top_q == '0) ? BK_CHECK : BK_SCAN_RD;
							end
						end
						KIND_READ: begin
							if (!addr_beyond) begin
								state_d = BK_READ_WAIT;
							end
						end
						KIND_ADD, KIND_CLEAR: ;
					endcase
				end
			end
			BK_READ_WAIT: state_d = BK_IDLE;
			BK_SCAN_RD:   state_d = BK_SCAN_CMP;
			BK_SCAN_CMP: begin
				if (match && last_match) begin
					state_d = BK_IDLE;
				end else if (pos_nx == top_q) begin
					state_d = BK_CHECK;
				end else begin
					state_d = BK_SCAN_RD;
				end
			end
			BK_CHECK:  state_d = fits ? BK_APP_RD : BK_IDLE;
			BK_APP_RD: state_d = BK_APP_WR;
			BK_APP_WR: state_d = last_match ? BK_IDLE : BK_APP_RD;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		e_kind    = KIND_FINISH;
		e_off     = '0;
		e_len     = '0;
		e_byte    = '0;
		e_top     = top_q;
		e_status  = ST_OK;
		st_we     = 1'b0;
		pd_we     = 1'b0;
		top_d     = top_q;
		count_d   = count_q;
		pos_d     = pos_q;
		matched_d = matched_q;
		start_d   = start_q;
		have_d    = have_q;
		off_d     = off_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					e_kind = cmd_kind;
					unique case (cmd_kind)
						KIND_ADD: begin
							if (pend_full) begin
								emit     = 1'b1;
								e_status = ST_OVERFLOW;
							end else begin
								pd_we   = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						KIND_FINISH: begin
							if (count_q == '0) begin
								emit = 1'b1;
							end else begin
								pos_d     = '0;
								matched_d = '0;
								have_d    = 1'b0;
							end
						end
						KIND_READ: begin
							if (addr_beyond) begin
								emit     = 1'b1;
								e_status = ST_RANGE;
							end
						end
						KIND_CLEAR: begin
							emit  = 1'b1;
							top_d = '0;
							e_top = '0;
						end
					endcase
				end
			end
			BK_READ_WAIT: begin
				emit   = 1'b1;
				e_kind = KIND_READ;
				e_byte = st_rdata_q;
			end
			BK_SCAN_CMP: begin
				if (match) begin
					matched_d = matched_inc;
					pos_d     = pos_inc;
					if (!have_q) begin
						start_d = pos_q[AW-1:0];
						have_d  = 1'b1;
					end
					if (last_match) begin
						emit    = 1'b1;
						e_off   = have_q ? start_q : pos_q[AW-1:0];
						e_len   = count_q;
						count_d = '0;
					end
				end else begin
					matched_d = '0;
					pos_d     = pos_nx;
					have_d    = 1'b0;
				end
			end
			BK_CHECK: begin
				if (fits) begin
					off_d = have_q ? start_q : top_q[AW-1:0];
				end else begin
					emit     = 1'b1;
					e_len    = count_q;
					e_status = ST_OVERFLOW;
					count_d  = '0;
				end
			end
			BK_APP_WR: begin
				st_we     = 1'b1;
				top_d     = top_q + TW'(1);
				matched_d = matched_inc;
				if (last_match) begin
					emit    = 1'b1;
					e_off   = off_q;
					e_len   = count_q;
					e_top   = top_q + TW'(1);
					count_d = '0;
				end
			end
			BK_SCAN_RD, BK_APP_RD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			top_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		matched_q <= matched_d;
		start_q   <= start_d;
		have_q    <= have_d;
		off_q     <= off_d;
		if (emit) begin
			out_kind_q   <= e_kind;
			out_off_q    <= e_off;
			out_len_q    <= e_len;
			out_byte_q   <= e_byte;
			out_top_q    <= e_top;
			out_status_q <= e_status;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_kind   = out_kind_q;
	assign res_offset = out_off_q;
	assign res_length = out_len_q;
	assign res_byte   = out_byte_q;
	assign res_top    = out_top_q;
	assign res_status = out_status_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result loaded over a waiting result");

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TW'(STORE_DEPTH))
		else $error("store top beyond capacity");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN_RD || state_q == BK_SCAN_CMP || state_q == BK_CHECK ||
		 state_q == BK_APP_RD || state_q == BK_APP_WR) |-> (matched_q < count_q))
		else $error("match count reached sequence length inside merge");

	a_append_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_APP_WR) |=> (top_q == $past(top_q) + TW'(1)))
		else $error("append did not advance store top");

endmodule

/* hdl/overlap_merging_byte_packer_core.sv */
// Add and clear items: one per cycle unless a waiting result holds the back end.
// Read items: one registered store read, skipped for an address at or beyond the top.
// Finish items: scan read and compare per step (store and pending reads are registered),
//   then a capacity check, an append read and write per byte; restarts give O(top*len).
// Reset (arst_n low, asynchronous) empties the store top, pending count and queue;
//   store and pending memories are not cleared, so no clearing pass is needed.
module overlap_merging_byte_packer_core
	import obp_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF,
	localparam int AW    = $clog2(STORE_DEPTH),
	localparam int TW    = $clog2(STORE_DEPTH + 1),
	localparam int CW    = $clog2(SEQ_DEPTH + 1),
	localparam int IN_R  = 8 + AW,
	localparam int IN_W  = ((IN_R + 7) / 8) * 8,
	localparam int OUT_R = AW + CW + 8 + TW + 2,
	localparam int OUT_W = ((OUT_R + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // data_byte, read_address, zero fill
	input  logic [1:0]       s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // sequence_offset, sequence_length, read_byte,
	                                        // store_top, status, zero fill
	output logic [1:0]       m_axis_tuser   // result_kind
);

	localparam int QW = 2 + 8 + AW;

	// front: register and split each inbound transaction
	logic          f_valid;
	logic          f_ready;
	kind_t         f_kind;
	logic [7:0]    f_data;
	logic [AW-1:0] f_addr;

	// queue output toward the back end
	logic          q_valid;
	logic          q_ready;
	logic [QW-1:0] q_data;

	// back end result
	logic          r_valid;
	kind_t         r_kind;
	logic [AW-1:0] r_offset;
	logic [CW-1:0] r_length;
	logic [7:0]    r_byte;
	logic [TW-1:0] r_top;
	status_t       r_status;

	obp_front #(
		.AW   (AW),
		.IN_W (IN_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (f_valid),
		.cmd_ready     (f_ready),
		.cmd_kind      (f_kind),
		.cmd_data      (f_data),
		.cmd_addr      (f_addr)
	);

	// hold commands here so the front keeps taking bytes while a merge runs
	obp_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_addr, f_data, f_kind}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	// back: pending buffer, store, scan and append sequencer, output register
	obp_back #(
		.STORE_DEPTH (STORE_DEPTH),
		.SEQ_DEPTH   (SEQ_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd_kind   (kind_t'(q_data[1:0])),
		.cmd_data   (q_data[9:2]),
		.cmd_addr   (q_data[10 +: AW]),
		.res_valid  (r_valid),
		.res_ready  (m_axis_tready),
		.res_kind   (r_kind),
		.res_offset (r_offset),
		.res_length (r_length),
		.res_byte   (r_byte),
		.res_top    (r_top),
		.res_status (r_status)
	);

	// pack result fields from the lowest bit up, zero fill to whole bytes
	assign m_axis_tvalid = r_valid;
	assign m_axis_tuser  = r_kind;
	assign m_axis_tdata  = OUT_W'({r_status, r_top, r_byte, r_length, r_offset});

endmodule

/* tb/sv/tb_overlap_merging_byte_packer_core.sv */
`timescale 1ns / 1ps

module tb_overlap_merging_byte_packer_core;
	import obp_pkg::*;

	localparam int STORE_D        = STORE_DEPTH_DEF;
	localparam int SEQ_D          = SEQ_DEPTH_DEF;
	localparam int IN_W           = 24;
	localparam int OUT_W          = 48;
	localparam int RANDOM_ITEMS   = 550;
	// keep the store short in the random phase so that the restart scans stay cheap
	localparam int RANDOM_TOP_CAP = 200;
	localparam int DRAIN_CYCLES   = 50;

	typedef struct {
		kind_t       kind;
		logic [11:0] offset;
		logic [8:0]  length;
		logic [7:0]  rbyte;
		logic [12:0] top;
		status_t     status;
	} pack_result_t;

	// Mirror of the packer: store, top, pending sequence, and the results still owed.
	class packing_tracker;
		logic [7:0]   store_mem [STORE_D];
		logic [12:0]  top;
		logic [7:0]   pend [SEQ_D];
		logic [8:0]   pend_cnt;
		pack_result_t results_due [$];
		int           errors;

		function new();
			top = '0;
			pend_cnt = '0;
			errors = 0;
		endfunction

		function void due(kind_t kind, logic [11:0] offset, logic [8:0] length,
			logic [7:0] rbyte, status_t status);
			pack_result_t r;
			r.kind = kind;
			r.offset = offset;
			r.length = length;
			r.rbyte = rbyte;
			r.top = top;
			r.status = status;
			results_due.push_back(r);
		endfunction

		// Naive restart search; on a miss after a partial match resume one past its start.
		// Fall through with the tail overlap and append the remainder if it fits.
		function logic [11:0] merge_pending(output bit ovf);
			int unsigned size, pos, matched, start;
			bit have_start;
			size = pend_cnt;
			pos = 0;
			matched = 0;
			start = 0;
			have_start = 1'b0;
			ovf = 1'b0;
			if (size == 0)
				return '0;
			while (pos < top) begin
				if (store_mem[pos] != pend[matched]) begin
					matched = 0;
					if (!have_start) begin
						pos++;
					end else begin
						pos = start + 1;
						have_start = 1'b0;
					end
				end else begin
					if (!have_start) begin
						start = pos;
						have_start = 1'b1;
					end
					pos++;
					matched++;
					if (matched == size)
						return 12'(start);
				end
			end
			if (top + (size - matched) > STORE_D) begin
				ovf = 1'b1;
				return '0;
			end
			while (matched < size) begin
				store_mem[top] = pend[matched];
				top++;
				matched++;
			end
			return have_start ? 12'(start) : 12'(pos);
		endfunction

		function void take_item(kind_t kind, logic [7:0] dbyte, logic [11:0] raddr);
			bit ovf;
			logic [8:0] len;
			logic [11:0] off;
			case (kind)
				KIND_ADD: begin
					if (pend_cnt >= SEQ_D) begin
						due(KIND_ADD, '0, '0, '0, ST_OVERFLOW);
					end else begin
						pend[pend_cnt] = dbyte;
						pend_cnt++;
					end
				end
				KIND_FINISH: begin
					len = pend_cnt;
					off = merge_pending(ovf);
					pend_cnt = '0;
					due(KIND_FINISH, off, len, '0, ovf ? ST_OVERFLOW : ST_OK);
				end
				KIND_READ: begin
					if (raddr >= top)
						due(KIND_READ, '0, '0, '0, ST_RANGE);
					else
						due(KIND_READ, '0, '0, store_mem[raddr], ST_OK);
				end
				default: begin
					top = '0;
					due(KIND_CLEAR, '0, '0, '0, ST_OK);
				end
			endcase
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] tdata, logic [1:0] tuser);
			pack_result_t want;
			if (results_due.size() == 0) begin
				$error("result with no transaction owed: tuser %0d tdata %h", tuser, tdata);
				errors++;
				return;
			end
			want = results_due.pop_front();
			check_field("result_kind", want.kind, tuser);
			check_field("sequence_offset", want.offset, tdata[11:0]);
			check_field("sequence_length", want.length, tdata[20:12]);
			check_field("read_byte", want.rbyte, tdata[28:21]);
			check_field("store_top", want.top, tdata[41:29]);
			check_field("status", want.status, tdata[43:42]);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;   // data_byte, read_address, zero fill
	logic [1:0]       s_axis_tuser = '0;   // kind
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // sequence_offset, sequence_length, read_byte,
	                                       // store_top, status, zero fill
	logic [1:0]       m_axis_tuser;        // result_kind

	packing_tracker tracker = new();

	int burst_left = 0;
	int items_sent = 0;

	overlap_merging_byte_packer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: check each transaction, then pick the next tready from a stall pattern
	// that switches between no stalls, short stalls and long stalls.
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_stall = 0;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata, m_axis_tuser);
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			case (rx_mode)
				1: begin
					if ($urandom_range(0, 7) == 0)
						rx_stall = $urandom_range(1, 3);
				end
				2: begin
					if ($urandom_range(0, 3) == 0)
						rx_stall = $urandom_range(1, 30);
				end
				default: ;
			endcase
		end
	end

	// Sender: work in bursts, drop tvalid for a random gap between them, hold the
	// transaction until tready, then note it for prediction.
	task automatic send_item(kind_t kind, logic [7:0] dbyte, logic [11:0] raddr);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {4'd0, raddr, dbyte};
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_item(kind, dbyte, raddr);
		items_sent++;
	endtask

	// Hold the sender until every owed result has come back.
	task automatic await_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.results_due.size() != 0);
	endtask

	task automatic send_bytes(int count);
		repeat (count) send_item(KIND_ADD, 8'($urandom), 12'($urandom));
	endtask

	// Hand-picked items: empty store reads, empty sequence, plain append, whole match,
	// tail overlap, reads around the top, clear keeping the pending bytes.
	task automatic run_directed();
		send_item(KIND_READ, 8'h00, 12'h000);
		send_item(KIND_READ, 8'hFF, 12'hFFF);
		send_item(KIND_FINISH, 8'h00, 12'h000);
		send_item(KIND_ADD, 8'h00, 12'hFFF);
		send_item(KIND_ADD, 8'hFF, 12'h000);
		send_item(KIND_ADD, 8'h12, 12'h000);
		send_item(KIND_FINISH, 8'h00, 12'h000);
		send_item(KIND_ADD, 8'hFF, 12'h000);
		send_item(KIND_ADD, 8'h12, 12'h000);
		send_item(KIND_FINISH, 8'h00, 12'h000);
		send_item(KIND_ADD, 8'h12, 12'h000);
		send_item(KIND_ADD, 8'h34, 12'h000);
		send_item(KIND_FINISH, 8'h00, 12'h000);
		send_item(KIND_READ, 8'h00, 12'h000);
		send_item(KIND_READ, 8'h00, 12'h003);
		send_item(KIND_READ, 8'h00, 12'h004);
		send_item(KIND_CLEAR, 8'hFF, 12'hFFF);
		send_item(KIND_READ, 8'h00, 12'h000);
		send_item(KIND_ADD, 8'hAA, 12'h000);
		send_item(KIND_CLEAR, 8'h00, 12'h000);
		send_item(KIND_FINISH, 8'h00, 12'h000);
		send_item(KIND_READ, 8'h00, 12'h000);
	endtask

	// Fill the store to the last byte with full-length sequences, then push it over:
	// pending full, store full, and a short sequence against a full store.
	task automatic run_fill();
		int rest;
		send_item(KIND_CLEAR, 8'h00, 12'h000);
		while (tracker.top + SEQ_D <= STORE_D) begin
			send_bytes(SEQ_D);
			send_item(KIND_FINISH, 8'($urandom), 12'($urandom));
		end
		rest = STORE_D - tracker.top;
		send_bytes(rest);
		send_item(KIND_FINISH, 8'($urandom), 12'($urandom));
		send_item(KIND_READ, 8'h00, 12'hFFF);
		send_item(KIND_READ, 8'h00, 12'(tracker.top - 1));
		send_bytes(SEQ_D + 1);
		send_item(KIND_FINISH, 8'($urandom), 12'($urandom));
		send_bytes(1);
		send_item(KIND_FINISH, 8'($urandom), 12'($urandom));
	endtask

	// One well-formed sequence: a copy of a stretch of the store (often running off
	// the tail), a small alphabet that makes partial matches and restarts common,
	// or full-range bytes. Now and then one byte is spoiled.
	task automatic send_sequence();
		int len, mode, start, reach, i;
		logic [7:0] b;
		len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
		if ($urandom_range(0, 19) == 0)
			len = $urandom_range(9, 40);
		mode = $urandom_range(0, 2);
		start = 0;
		if (mode == 0 && tracker.top != 0) begin
			if ($urandom_range(0, 1) == 0) begin
				start = $urandom_range(0, tracker.top - 1);
			end else begin
				reach = (tracker.top < 8) ? tracker.top : 8;
				start = tracker.top - $urandom_range(1, reach);
			end
		end
		for (i = 0; i < len; i++) begin
			if (mode == 0 && tracker.top != 0 && start + i < tracker.top)
				b = tracker.store_mem[start + i];
			else if (mode == 2)
				b = 8'($urandom);
			else
				b = 8'($urandom_range(0, 3) * 8'h55);
			if ($urandom_range(0, 29) == 0)
				b = 8'($urandom);
			send_item(KIND_ADD, b, 12'($urandom));
		end
		send_item(KIND_FINISH, 8'($urandom), 12'($urandom));
	endtask

	task automatic run_random();
		int base, pick;
		logic [11:0] addr;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (tracker.top > RANDOM_TOP_CAP) begin
				send_item(KIND_CLEAR, 8'($urandom), 12'($urandom));
			end else if (pick < 70) begin
				send_sequence();
			end else if (pick < 85) begin
				addr = 12'($urandom);
				if (tracker.top != 0 && $urandom_range(0, 3) != 0)
					addr = 12'($urandom_range(0, tracker.top - 1));
				else if ($urandom_range(0, 3) == 0)
					addr = 12'(tracker.top);
				send_item(KIND_READ, 8'($urandom), addr);
			end else if (pick < 90) begin
				send_item(KIND_CLEAR, 8'($urandom), 12'($urandom));
			end else begin
				send_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 12'($urandom));
			end
			if ($urandom_range(0, 39) == 0)
				await_results();
		end
	endtask

	initial begin
		// drive reset low after every process has started so the falling edge is seen
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		await_results();
		run_fill();
		await_results();
		send_item(KIND_CLEAR, 8'h00, 12'h000);
		run_random();
		await_results();
		// give a stray extra result time to show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/obp_pkg.sv
hdl/obp_front.sv
hdl/obp_queue.sv
hdl/obp_back.sv
hdl/overlap_merging_byte_packer_core.sv
tb/sv/tb_overlap_merging_byte_packer_core.sv
